// ===== rtl/cfdc_pkg.sv =====
package cfdc_pkg;

  localparam int TABLE_DEPTH  = 8;
  localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
  localparam int SAMPLE_WIDTH = 16;
  localparam int POWER_WIDTH  = 9;
  localparam int COEF_WIDTH   = 16;
  localparam int COUNT_WIDTH  = 4;
  localparam int FRAC_BITS    = 16;
  localparam int FILT_WIDTH   = 36;
  localparam int QUOT_WIDTH   = FRAC_BITS + 1;
  localparam int DIFF_WIDTH   = POWER_WIDTH + 1;
  localparam int CFG_WIDTH    = COEF_WIDTH;

  localparam logic [COEF_WIDTH-1:0]  COEF_RESET   = 16'd6554;
  localparam logic [COUNT_WIDTH-1:0] POINTS_RESET = 4'd8;

  localparam logic REG_FILTER_COEF = 1'b0;
  localparam logic REG_POINTS      = 1'b1;

  localparam logic MODE_WRITE      = 1'b0;
  localparam logic MODE_COMPENSATE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NOCAL = 2'd1,
    STATUS_ABOVE = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [POWER_WIDTH-1:0]  power;
    logic signed [SAMPLE_WIDTH-1:0] ox;
    logic signed [SAMPLE_WIDTH-1:0] oy;
    logic signed [SAMPLE_WIDTH-1:0] oz;
  } entry_t;

endpackage

// ===== rtl/cfdc_if.sv =====
interface cfdc_in_if;
  import cfdc_pkg::*;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [TABLE_AW-1:0]            entry_index;
  logic signed [POWER_WIDTH-1:0]  entry_power;
  logic signed [SAMPLE_WIDTH-1:0] entry_offset_x;
  logic signed [SAMPLE_WIDTH-1:0] entry_offset_y;
  logic signed [SAMPLE_WIDTH-1:0] entry_offset_z;
  logic signed [POWER_WIDTH-1:0]  drive_power;
  logic signed [SAMPLE_WIDTH-1:0] field_x;
  logic signed [SAMPLE_WIDTH-1:0] field_y;
  logic signed [SAMPLE_WIDTH-1:0] field_z;

  modport source (output valid, mode, entry_index, entry_power, entry_offset_x,
                  entry_offset_y, entry_offset_z, drive_power, field_x, field_y,
                  field_z, input ready);
  modport sink (input valid, mode, entry_index, entry_power, entry_offset_x,
                entry_offset_y, entry_offset_z, drive_power, field_x, field_y,
                field_z, output ready);
endinterface

interface cfdc_out_if;
  import cfdc_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] corrected_x;
  logic signed [SAMPLE_WIDTH-1:0] corrected_y;
  logic signed [SAMPLE_WIDTH-1:0] corrected_z;
  logic [1:0]                     status;

  modport source (output valid, corrected_x, corrected_y, corrected_z, status,
                  input ready);
  modport sink (input valid, corrected_x, corrected_y, corrected_z, status,
                output ready);
endinterface

// ===== rtl/cfdc_ram.sv =====
module cfdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cfdc_div.sv =====
module cfdc_div
  import cfdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIFF_WIDTH-1:0] dividend,
  input  logic [DIFF_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [QUOT_WIDTH-1:0] quot
);

  // dividend <= divisor, so the quotient of (dividend << 16) / divisor is at most 2^16
  logic                   busy;
  logic [4:0]             cnt;
  logic [DIFF_WIDTH-1:0]  rem;
  logic [DIFF_WIDTH-1:0]  den;
  logic [DIFF_WIDTH:0]    rem2;
  logic                   take;

  always_comb begin
    rem2 = {rem, 1'b0};
    take = rem2 >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        den  <= divisor;
        if (dividend == divisor) begin
          rem  <= '0;
          quot <= QUOT_WIDTH'(1);
        end else begin
          rem  <= dividend;
          quot <= '0;
        end
      end else if (busy) begin
        rem  <= take ? DIFF_WIDTH'(rem2 - {1'b0, den}) : DIFF_WIDTH'(rem2);
        quot <= {quot[QUOT_WIDTH-2:0], take};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/coil_field_distortion_compensator_core.sv =====
// Coil field distortion compensator.
// req carries words in: mode 0 writes one calibration point (power and x/y/z
// offsets), mode 1 compensates a magnetometer sample taken at a coil power.
// rsp returns one word per request: the corrected sample and a status
// (ok, not calibrated, power above table); a table write returns zeros.
// cfg_we/cfg_index/cfg_wdata set the filter coefficient and point count; the
// user must see that they are written only while the block is idle; the
// block itself does not enforce it. A table write goes through S_OUT to the
// rsp register. A sample takes a table scan over the point memory up to entry
// last_idx, the bit-serial divider when interpolating, the S_MUL, S_DELTA,
// S_FMUL and S_ACC states per axis for the multiply and filter update, and S_CORR for rounding.
// One word is in flight at a time; req.ready is high only when idle.
// A finished word sits in the rsp register; the next request is taken while
// it waits, and its own result waits until rsp is taken.
// Reset clears the filter, the calibrated flag and the registers to their
// defaults; the point memory is not cleared and must be written before use.
module coil_field_distortion_compensator_core
  import cfdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  cfdc_in_if.sink              req,
  cfdc_out_if.source           rsp,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_wdata
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_MUL    = 9'b000001000,
    S_DELTA  = 9'b000010000,
    S_FMUL   = 9'b000100000,
    S_ACC    = 9'b001000000,
    S_CORR   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  localparam int PROD_WIDTH = QUOT_WIDTH + 1 + SAMPLE_WIDTH + 1;
  localparam int QW         = FILT_WIDTH + 1 - FRAC_BITS;
  localparam int CQ_WIDTH   = COEF_WIDTH + 1 + QW;
  localparam int RND_WIDTH  = FILT_WIDTH + 1 - FRAC_BITS;

  state_t state;

  logic [COEF_WIDTH-1:0]  coef;
  logic [COUNT_WIDTH-1:0] points;
  logic [TABLE_AW-1:0]    last_idx;
  logic                   calibrated;

  logic signed [POWER_WIDTH-1:0]  pwr;
  logic signed [SAMPLE_WIDTH-1:0] smp    [3];
  logic signed [SAMPLE_WIDTH-1:0] lo_off [3];
  logic signed [SAMPLE_WIDTH-1:0] hi_off [3];
  logic signed [FILT_WIDTH-1:0]   filt   [3];
  logic [TABLE_AW-1:0]            idx;
  logic [1:0]                     ax;
  entry_t                         prev;
  logic [QUOT_WIDTH-1:0]          frac;

  logic signed [PROD_WIDTH-1:0]   prod;
  logic signed [FILT_WIDTH:0]     delta;
  logic signed [CQ_WIDTH-1:0]     cq;
  logic [2*COEF_WIDTH-1:0]        cr;

  logic signed [SAMPLE_WIDTH-1:0] res [3];
  status_t                        res_status;

  logic                           ram_we;
  logic [TABLE_AW-1:0]            ram_raddr;
  entry_t                         ram_wdata;
  entry_t                         ent;

  logic                           div_start;
  logic                           div_done;
  logic [DIFF_WIDTH-1:0]          div_num;
  logic [DIFF_WIDTH-1:0]          div_den;
  logic [QUOT_WIDTH-1:0]          div_quot;

  logic                           accept;
  logic                           hit;
  logic signed [SAMPLE_WIDTH:0]   diff;
  logic signed [PROD_WIDTH-1:0]   prod_c;
  logic signed [FILT_WIDTH-1:0]   newv;
  logic signed [QW-1:0]           dq;
  logic signed [CQ_WIDTH-1:0]     cq_c;
  logic signed [CQ_WIDTH-1:0]     filt_sum;
  logic signed [SAMPLE_WIDTH-1:0] corr [3];

  always_comb begin
    if (points < COUNT_WIDTH'(2)) begin
      last_idx = TABLE_AW'(1);
    end else if (points > COUNT_WIDTH'(TABLE_DEPTH)) begin
      last_idx = TABLE_AW'(TABLE_DEPTH - 1);
    end else begin
      last_idx = TABLE_AW'(points - COUNT_WIDTH'(1));
    end
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign ram_we    = accept && (req.mode == MODE_WRITE);
  assign ram_wdata = '{power: req.entry_power, ox: req.entry_offset_x,
                       oy: req.entry_offset_y, oz: req.entry_offset_z};
  assign ram_raddr = (state == S_SEARCH) ? TABLE_AW'(idx + TABLE_AW'(1)) : '0;
  assign hit       = (pwr <= ent.power);
  assign div_num   = DIFF_WIDTH'(DIFF_WIDTH'(pwr) - DIFF_WIDTH'(prev.power));
  assign div_den   = DIFF_WIDTH'(DIFF_WIDTH'(ent.power) - DIFF_WIDTH'(prev.power));
  assign div_start = (state == S_SEARCH) && hit && (idx != '0);

  cfdc_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.entry_index),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ent)
  );

  cfdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    diff   = (SAMPLE_WIDTH+1)'(hi_off[ax]) - (SAMPLE_WIDTH+1)'(lo_off[ax]);
    prod_c = $signed({1'b0, frac}) * diff;
    newv   = $signed({{(FILT_WIDTH-SAMPLE_WIDTH-FRAC_BITS){lo_off[ax][SAMPLE_WIDTH-1]}},
                      lo_off[ax], {FRAC_BITS{1'b0}}}) + FILT_WIDTH'(prod);
    dq     = delta[FILT_WIDTH:FRAC_BITS];
    cq_c   = $signed({1'b0, coef}) * dq;
    filt_sum = CQ_WIDTH'(filt[ax]) + cq
             + $signed({{(CQ_WIDTH-COEF_WIDTH){1'b0}}, cr[2*COEF_WIDTH-1:COEF_WIDTH]});
  end

  for (genvar a = 0; a < 3; a++) begin : g_corr
    logic signed [FILT_WIDTH:0]     rsum;
    logic signed [RND_WIDTH-1:0]    rnd;
    logic signed [RND_WIDTH:0]      v;
    always_comb begin
      rsum = (FILT_WIDTH+1)'(filt[a]) + (FILT_WIDTH+1)'(1 << (FRAC_BITS - 1));
      rnd  = rsum[FILT_WIDTH:FRAC_BITS];
      v    = (RND_WIDTH+1)'(smp[a]) - (RND_WIDTH+1)'(rnd);
      if (v < (RND_WIDTH+1)'(-(1 << (SAMPLE_WIDTH - 1)))) begin
        corr[a] = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else if (v > (RND_WIDTH+1)'((1 << (SAMPLE_WIDTH - 1)) - 1)) begin
        corr[a] = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else begin
        corr[a] = SAMPLE_WIDTH'(v);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RESET;
      points <= POINTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_COEF: coef <= cfg_wdata[COEF_WIDTH-1:0];
        REG_POINTS:      points <= cfg_wdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      calibrated <= 1'b0;
      rsp.valid  <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        filt[a] <= '0;
      end
    end else begin
      if (rsp.ready && (state != S_OUT)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pwr    <= req.drive_power;
            smp[0] <= req.field_x;
            smp[1] <= req.field_y;
            smp[2] <= req.field_z;
            idx    <= '0;
            if (req.mode == MODE_WRITE) begin
              if (req.entry_index == last_idx) begin
                calibrated <= 1'b1;
              end
              for (int a = 0; a < 3; a++) begin
                res[a] <= '0;
              end
              res_status <= STATUS_OK;
              state <= S_OUT;
            end else if (!calibrated) begin
              res[0] <= req.field_x;
              res[1] <= req.field_y;
              res[2] <= req.field_z;
              res_status <= STATUS_NOCAL;
              state <= S_OUT;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          prev <= ent;
          ax   <= '0;
          if (hit) begin
            hi_off[0] <= ent.ox;
            hi_off[1] <= ent.oy;
            hi_off[2] <= ent.oz;
            if (idx == '0) begin
              lo_off[0] <= ent.ox;
              lo_off[1] <= ent.oy;
              lo_off[2] <= ent.oz;
              frac  <= '0;
              state <= S_MUL;
            end else begin
              lo_off[0] <= prev.ox;
              lo_off[1] <= prev.oy;
              lo_off[2] <= prev.oz;
              state <= S_DIV;
            end
          end else if (idx == last_idx) begin
            for (int a = 0; a < 3; a++) begin
              res[a] <= smp[a];
            end
            res_status <= STATUS_ABOVE;
            state <= S_OUT;
          end else begin
            idx <= idx + TABLE_AW'(1);
          end
        end
        S_DIV: begin
          if (div_done) begin
            frac  <= div_quot;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= prod_c;
          state <= S_DELTA;
        end
        S_DELTA: begin
          delta <= (FILT_WIDTH+1)'(newv) - (FILT_WIDTH+1)'(filt[ax]);
          state <= S_FMUL;
        end
        S_FMUL: begin
          cq    <= cq_c;
          cr    <= coef * delta[FRAC_BITS-1:0];
          state <= S_ACC;
        end
        S_ACC: begin
          filt[ax] <= FILT_WIDTH'(filt_sum);
          if (ax == 2'd2) begin
            state <= S_CORR;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_MUL;
          end
        end
        S_CORR: begin
          for (int a = 0; a < 3; a++) begin
            res[a] <= corr[a];
          end
          res_status <= STATUS_OK;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.corrected_x <= res[0];
            rsp.corrected_y <= res[1];
            rsp.corrected_z <= res[2];
            rsp.status      <= res_status;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cfdc_checker.sv =====
module cfdc_prop_checker
  import cfdc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  cfdc_in_if.sink    req,
  cfdc_out_if.source rsp
);

  // one word in flight: no back-to-back accepts
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !rsp.valid && req.ready)
    else $error("not idle after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)
      && $stable(rsp.corrected_x) && $stable(rsp.corrected_y)
      && $stable(rsp.corrected_z))
    else $error("stalled response word changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status == STATUS_OK || rsp.status == STATUS_NOCAL
      || rsp.status == STATUS_ABOVE)
    else $error("bad status");

endmodule

bind coil_field_distortion_compensator_core cfdc_prop_checker u_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);
